### hdl/rmq_pkg.sv
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int EW = 16;
    localparam int RW = EW + 3;
    localparam int NW = 2 * EW;
    localparam int SW = NW / 2;
    localparam int VW = SW + 2;
    localparam int MW = EW + 1;
    localparam int QW = NW;

    typedef struct packed {
        logic signed [EW-1:0] elem_0_0;
        logic signed [EW-1:0] elem_0_1;
        logic signed [EW-1:0] elem_0_2;
        logic signed [EW-1:0] elem_1_0;
        logic signed [EW-1:0] elem_1_1;
        logic signed [EW-1:0] elem_1_2;
        logic signed [EW-1:0] elem_2_0;
        logic signed [EW-1:0] elem_2_1;
        logic signed [EW-1:0] elem_2_2;
    } t_in;

    typedef struct packed {
        logic signed [EW-1:0] quat_x;
        logic signed [EW-1:0] quat_y;
        logic signed [EW-1:0] quat_z;
        logic signed [EW-1:0] quat_w;
        logic                 degenerate;
    } t_out;

    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } t_branch;

endpackage

### hdl/rotation_matrix_to_quaternion.sv
// rotation matrix to unit quaternion, shepperd's method, signed q2.14
// input channel: i_valid / o_stall with the nine matrix elements in i_data;
// a transaction is taken on a rising edge with i_valid high and o_stall low
// output channel: o_valid / i_stall with quat_x, quat_y, quat_z, quat_w and
// the degenerate flag in o_data
// throughput: one matrix per cycle while the receiver does not stall
// pipeline: branch and radicand are registered at the accepting edge,
// then sixteen stages of bit-serial square root, one to set up the division,
// thirty-two for the three restoring dividers in lockstep and one for
// rounding, saturation and the output register
// a radicand that is not positive gives zero components and degenerate high
// reset (synchronous, active low) empties the pipeline; data is dropped
// while the receiver stalls a valid result the whole pipeline holds and
// o_stall is raised, so nothing is lost or repeated
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef struct packed {
        t_branch                   br;
        logic                      deg;
        logic [2:0]                neg;
        logic [2:0][MW-1:0]        mag;
    } t_side;

    typedef struct packed {
        logic [VW-1:0] rem;
        logic [SW-1:0] root;
        logic [NW-1:0] n;
        t_side         side;
    } t_sq;

    typedef struct packed {
        logic [2:0][VW-1:0] rem;
        logic [2:0][QW-1:0] q;
        logic [2:0][QW-1:0] num;
        logic [VW-1:0]      dv;
        logic [SW-1:0]      s;
        t_side              side;
    } t_dv;

    t_sq  r_sq [0:SW];
    t_sq  n_sq [0:SW];
    logic r_sqv [0:SW];
    t_dv  r_dv [0:QW];
    t_dv  n_dv [0:QW];
    logic r_dvv [0:QW];
    t_out r_out;
    t_out n_out;
    logic r_ov;
    logic w_en;

    assign w_en    = !(r_ov && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_ov;
    assign o_data  = r_out;

    // branch, radicand and off-diagonal pairs
    always_comb begin
        logic signed [RW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
        logic signed [RW-1:0] t, r, da, db, dc;
        logic signed [RW-1:0] one;
        t_branch br;
        logic [VW-1:0] rem2, trial;
        logic ge;
        one = RW'(1) <<< FRAC_BITS;
        m00 = RW'(i_data.elem_0_0);
        m01 = RW'(i_data.elem_0_1);
        m02 = RW'(i_data.elem_0_2);
        m10 = RW'(i_data.elem_1_0);
        m11 = RW'(i_data.elem_1_1);
        m12 = RW'(i_data.elem_1_2);
        m20 = RW'(i_data.elem_2_0);
        m21 = RW'(i_data.elem_2_1);
        m22 = RW'(i_data.elem_2_2);
        t = m00 + m11 + m22;
        if (t > 0) begin
            br = BR_W;
            r  = t + one;
            da = m12 - m21;
            db = m20 - m02;
            dc = m01 - m10;
        end else if (m00 >= m11 && m00 >= m22) begin
            br = BR_X;
            r  = one + m00 - m11 - m22;
            da = m01 + m10;
            db = m02 + m20;
            dc = m12 - m21;
        end else if (m11 > m22) begin
            br = BR_Y;
            r  = one + m11 - m00 - m22;
            da = m10 + m01;
            db = m21 + m12;
            dc = m20 - m02;
        end else begin
            br = BR_Z;
            r  = one + m22 - m00 - m11;
            da = m20 + m02;
            db = m21 + m12;
            dc = m01 - m10;
        end
        n_sq[0].rem       = '0;
        n_sq[0].root      = '0;
        n_sq[0].side.br   = br;
        n_sq[0].side.deg  = (r <= 0);
        n_sq[0].n         = (r > 0) ? (NW'(r[RW-2:0]) << FRAC_BITS) : '0;
        n_sq[0].side.neg  = {dc[RW-1], db[RW-1], da[RW-1]};
        n_sq[0].side.mag[0] = MW'(da[RW-1] ? -da : da);
        n_sq[0].side.mag[1] = MW'(db[RW-1] ? -db : db);
        n_sq[0].side.mag[2] = MW'(dc[RW-1] ? -dc : dc);

        // square root, one result bit per stage
        for (int i = 0; i < SW; i++) begin
            rem2  = {r_sq[i].rem[VW-3:0], r_sq[i].n[NW-1:NW-2]};
            trial = {r_sq[i].root, 2'b01};
            ge    = (rem2 >= trial);
            n_sq[i+1].rem  = ge ? rem2 - trial : rem2;
            n_sq[i+1].root = {r_sq[i].root[SW-2:0], ge};
            n_sq[i+1].n    = r_sq[i].n << 2;
            n_sq[i+1].side = r_sq[i].side;
        end
    end

    // division set-up and restoring division, one quotient bit per stage
    always_comb begin
        logic [VW-1:0] rem2;
        logic ge;
        n_dv[0].s    = r_sq[SW].root;
        n_dv[0].dv   = {1'b0, r_sq[SW].root, 1'b0};
        n_dv[0].side = r_sq[SW].side;
        for (int k = 0; k < 3; k++) begin
            n_dv[0].rem[k] = '0;
            n_dv[0].q[k]   = '0;
            n_dv[0].num[k] = (QW'(r_sq[SW].side.mag[k]) << FRAC_BITS)
                           + QW'(r_sq[SW].root);
        end
        for (int i = 0; i < QW; i++) begin
            n_dv[i+1].s    = r_dv[i].s;
            n_dv[i+1].dv   = r_dv[i].dv;
            n_dv[i+1].side = r_dv[i].side;
            for (int k = 0; k < 3; k++) begin
                rem2 = {r_dv[i].rem[k][VW-2:0], r_dv[i].num[k][QW-1]};
                ge   = (rem2 >= r_dv[i].dv);
                n_dv[i+1].rem[k] = ge ? rem2 - r_dv[i].dv : rem2;
                n_dv[i+1].q[k]   = {r_dv[i].q[k][QW-2:0], ge};
                n_dv[i+1].num[k] = r_dv[i].num[k] << 1;
            end
        end
    end

    // rounding, saturation and component placement
    always_comb begin
        logic signed [EW-1:0] v [0:2];
        logic signed [EW-1:0] diag;
        logic [QW-1:0] q;
        logic [SW:0] sp;
        for (int k = 0; k < 3; k++) begin
            q = r_dv[QW].q[k];
            if (r_dv[QW].side.neg[k]) begin
                if (q > QW'(2 ** (EW - 1)))
                    v[k] = {1'b1, {(EW-1){1'b0}}};
                else
                    v[k] = EW'(-q);
            end else begin
                if (q > QW'(2 ** (EW - 1) - 1))
                    v[k] = {1'b0, {(EW-1){1'b1}}};
                else
                    v[k] = EW'(q);
            end
        end
        sp   = {1'b0, r_dv[QW].s} + 1'b1;
        diag = EW'(sp >> 1);
        case (r_dv[QW].side.br)
            BR_W: begin
                n_out.quat_x = v[0];
                n_out.quat_y = v[1];
                n_out.quat_z = v[2];
                n_out.quat_w = diag;
            end
            BR_X: begin
                n_out.quat_x = diag;
                n_out.quat_y = v[0];
                n_out.quat_z = v[1];
                n_out.quat_w = v[2];
            end
            BR_Y: begin
                n_out.quat_x = v[0];
                n_out.quat_y = diag;
                n_out.quat_z = v[1];
                n_out.quat_w = v[2];
            end
            default: begin
                n_out.quat_x = v[0];
                n_out.quat_y = v[1];
                n_out.quat_z = diag;
                n_out.quat_w = v[2];
            end
        endcase
        n_out.degenerate = r_dv[QW].side.deg;
        if (r_dv[QW].side.deg) begin
            n_out.quat_x = '0;
            n_out.quat_y = '0;
            n_out.quat_z = '0;
            n_out.quat_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= SW; i++) r_sqv[i] <= 1'b0;
            for (int i = 0; i <= QW; i++) r_dvv[i] <= 1'b0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_sqv[0] <= i_valid;
            for (int i = 0; i < SW; i++) r_sqv[i+1] <= r_sqv[i];
            r_dvv[0] <= r_sqv[SW];
            for (int i = 0; i < QW; i++) r_dvv[i+1] <= r_dvv[i];
            r_ov <= r_dvv[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i <= SW; i++) r_sq[i] <= n_sq[i];
            for (int i = 0; i <= QW; i++) r_dv[i] <= n_dv[i];
            r_out <= n_out;
        end
    end

endmodule

### hdl/rmq_checker.sv
module rmq_props
    import rmq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output stalled");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("stall without a pending result");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.quat_x == 0 && o_data.quat_y == 0
            && o_data.quat_z == 0 && o_data.quat_w == 0)
        else $error("degenerate result not zero");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind rotation_matrix_to_quaternion rmq_props u_rmq_props (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);

### verif/rmq_checker.sv
`timescale 1ns / 100ps

module rmq_checker
    import rmq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  logic o_stall,
    input  t_in  i_data,
    input  logic o_valid,
    input  logic i_stall,
    input  t_out o_data,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_degen_count
);

    t_out quat_fifo[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [EW-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[EW-1:0];
    endfunction

    function automatic longint round_div(longint d, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = longint'(d < 0 ? -d : d) << FRAC_BITS;
        q = (mag + s) / (2 * s);
        return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_out predict_quat(t_in m);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, rad, one;
        longint unsigned s, diag;
        longint q[4];
        t_branch br;
        t_out res;
        one = longint'(1) << FRAC_BITS;
        a00 = longint'(m.elem_0_0); a01 = longint'(m.elem_0_1);
        a02 = longint'(m.elem_0_2);
        a10 = longint'(m.elem_1_0); a11 = longint'(m.elem_1_1);
        a12 = longint'(m.elem_1_2);
        a20 = longint'(m.elem_2_0); a21 = longint'(m.elem_2_1);
        a22 = longint'(m.elem_2_2);
        tr = a00 + a11 + a22;
        if (tr > 0) begin
            br = BR_W; rad = tr + one;
        end else if (a00 >= a11 && a00 >= a22) begin
            br = BR_X; rad = one + a00 - a11 - a22;
        end else if (a11 > a22) begin
            br = BR_Y; rad = one + a11 - a00 - a22;
        end else begin
            br = BR_Z; rad = one + a22 - a00 - a11;
        end
        res = '0;
        if (rad <= 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        s = int_sqrt(longint'(rad) << FRAC_BITS);
        diag = (s + 1) >> 1;
        case (br)
            BR_W: begin
                q[3] = diag;
                q[0] = round_div(a12 - a21, s);
                q[1] = round_div(a20 - a02, s);
                q[2] = round_div(a01 - a10, s);
            end
            BR_X: begin
                q[0] = diag;
                q[1] = round_div(a01 + a10, s);
                q[2] = round_div(a02 + a20, s);
                q[3] = round_div(a12 - a21, s);
            end
            BR_Y: begin
                q[0] = round_div(a10 + a01, s);
                q[1] = diag;
                q[2] = round_div(a21 + a12, s);
                q[3] = round_div(a20 - a02, s);
            end
            default: begin
                q[0] = round_div(a20 + a02, s);
                q[1] = round_div(a21 + a12, s);
                q[2] = diag;
                q[3] = round_div(a01 - a10, s);
            end
        endcase
        res.quat_x = clamp16(q[0]);
        res.quat_y = clamp16(q[1]);
        res.quat_z = clamp16(q[2]);
        res.quat_w = clamp16(q[3]);
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_degen_count = 0;
    end

    assign o_pending = quat_fifo.size();

    always @(posedge i_clk) begin
        t_out exp_q;
        if (i_rst_n) begin
            if (i_valid && !o_stall) quat_fifo.push_back(predict_quat(i_data));
            if (o_valid && !i_stall) begin
                if (quat_fifo.size() == 0) begin
                    $error("unexpected result transaction");
                    o_fail_count++;
                end else begin
                    exp_q = quat_fifo.pop_front();
                    if (exp_q.degenerate) o_degen_count++;
                    if (o_data.quat_x !== exp_q.quat_x) begin
                        $error("quat_x exp %0d got %0d", exp_q.quat_x, o_data.quat_x);
                        o_fail_count++;
                    end
                    if (o_data.quat_y !== exp_q.quat_y) begin
                        $error("quat_y exp %0d got %0d", exp_q.quat_y, o_data.quat_y);
                        o_fail_count++;
                    end
                    if (o_data.quat_z !== exp_q.quat_z) begin
                        $error("quat_z exp %0d got %0d", exp_q.quat_z, o_data.quat_z);
                        o_fail_count++;
                    end
                    if (o_data.quat_w !== exp_q.quat_w) begin
                        $error("quat_w exp %0d got %0d", exp_q.quat_w, o_data.quat_w);
                        o_fail_count++;
                    end
                    if (o_data.degenerate !== exp_q.degenerate) begin
                        $error("degenerate exp %0b got %0b", exp_q.degenerate,
                               o_data.degenerate);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import rmq_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_data;
    logic o_valid;
    logic i_stall;
    t_out o_data;
    int   fail_count;
    int   pending;
    int   degen_count;
    int   sent;
    bit   stall_on;

    t_in  matrix_list[$];

    rotation_matrix_to_quaternion dut (.*);

    rmq_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_degen_count(degen_count)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("rotation_matrix_to_quaternion verification failed");
        $finish;
    end

    // receiver stall pattern, with quiet stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_on <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) < 3) stall_on <= ~stall_on;
            i_stall <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b0;
        end
    end

    function automatic t_in diag_mat(int a, int b, int c);
        t_in m;
        m = '0;
        m.elem_0_0 = 16'(a); m.elem_1_1 = 16'(b); m.elem_2_2 = 16'(c);
        return m;
    endfunction

    function automatic t_in rand_mat();
        t_in m;
        m = t_in'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        return m;
    endfunction

    // small perturbations of a signed permutation matrix
    function automatic t_in near_rotation();
        t_in m;
        int perm;
        int v [9];
        int k;
        perm = $urandom_range(0, 5);
        for (k = 0; k < 9; k++) v[k] = $urandom_range(0, 1200) - 600;
        case (perm)
            0: begin v[0] += 16384; v[4] += 16384; v[8] += 16384; end
            1: begin v[0] += 16384; v[5] += 16384; v[7] -= 16384; end
            2: begin v[1] += 16384; v[3] -= 16384; v[8] += 16384; end
            3: begin v[0] -= 16384; v[4] -= 16384; v[8] += 16384; end
            4: begin v[0] -= 16384; v[4] += 16384; v[8] -= 16384; end
            default: begin v[0] += 16384; v[4] -= 16384; v[8] -= 16384; end
        endcase
        m.elem_0_0 = 16'(v[0]); m.elem_0_1 = 16'(v[1]); m.elem_0_2 = 16'(v[2]);
        m.elem_1_0 = 16'(v[3]); m.elem_1_1 = 16'(v[4]); m.elem_1_2 = 16'(v[5]);
        m.elem_2_0 = 16'(v[6]); m.elem_2_1 = 16'(v[7]); m.elem_2_2 = 16'(v[8]);
        return m;
    endfunction

    initial begin
        t_in m;
        int k;
        int gap;
        int burst;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        sent = 0;

        // identity, four branches, equal diagonals, zero and negative traces, extremes
        matrix_list.push_back(diag_mat(16384, 16384, 16384));
        matrix_list.push_back(diag_mat(16384, -16384, -16384));
        matrix_list.push_back(diag_mat(-16384, 16384, -16384));
        matrix_list.push_back(diag_mat(-16384, -16384, 16384));
        matrix_list.push_back(diag_mat(0, 0, 0));
        matrix_list.push_back(diag_mat(-100, -100, -100));
        matrix_list.push_back(diag_mat(-16384, -16384, -16384));
        matrix_list.push_back(diag_mat(-32768, -32768, -32768));
        matrix_list.push_back(diag_mat(32767, 32767, 32767));
        matrix_list.push_back(diag_mat(-32768, 32767, 32767));
        matrix_list.push_back(diag_mat(-200, -200, -100));
        matrix_list.push_back(diag_mat(-8000, -8000, -8000));
        m = '1;
        matrix_list.push_back(m);
        m = {9{16'sh7fff}};
        matrix_list.push_back(m);
        m = {9{16'sh8000}};
        matrix_list.push_back(m);
        m = diag_mat(1, 0, 0);
        m.elem_0_1 = 16'sh7fff; m.elem_1_0 = 16'sh7fff;
        m.elem_1_2 = 16'sh8000; m.elem_2_1 = 16'sh7fff;
        matrix_list.push_back(m);
        m = diag_mat(-16384, -16383, -16384);
        m.elem_1_0 = 16'sh8000; m.elem_0_1 = 16'sh8000;
        matrix_list.push_back(m);
        m = diag_mat(0, 0, 16384);
        m.elem_0_1 = 16384; m.elem_1_0 = -16384;
        matrix_list.push_back(m);
        for (k = 0; k < 750; k++) begin
            if ($urandom_range(0, 9) < 7) matrix_list.push_back(near_rotation());
            else matrix_list.push_back(rand_mat());
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (matrix_list.size() > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && matrix_list.size() > 0) begin
                i_valid <= 1'b1;
                i_data <= matrix_list.pop_front();
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                sent++;
                burst--;
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0 || matrix_list.size() == 0) begin
                i_valid <= 1'b0;
                i_data <= rand_mat();
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        while (pending > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("sent %0d matrices over all four branches, %0d degenerate results seen",
                 sent, degen_count);
        $display("random sender bursts and receiver stalls throughout");
        if (fail_count == 0) begin
            $display("rotation_matrix_to_quaternion verification clean");
        end else begin
            $display("rotation_matrix_to_quaternion verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/rmq_pkg.sv
hdl/rotation_matrix_to_quaternion.sv
hdl/rmq_checker.sv
verif/rmq_checker.sv
verif/testbench.sv
